>>> hw/rtl/adsr_pkg.sv
// shared types and constants for the envelope generator
// no dependencies; imported by every module of the block
package adsr_pkg;

	// fixed point widths: level Q1.24, factors Q0.16
	localparam int unsigned LevelW  = 25;
	localparam int unsigned FactorW = 16;
	localparam int unsigned ProdW   = LevelW + FactorW;
	localparam int unsigned DacW    = 12;
	localparam int unsigned PhaseW  = 3;
	localparam int unsigned CfgAddrW = 2;

	localparam logic [LevelW-1:0]  FullScale = 25'd16777216;
	localparam logic [LevelW-1:0]  Margin    = 25'd16777;
	localparam logic [FactorW-1:0] DacMax    = 16'd4095;

	// phase codes
	localparam logic [PhaseW-1:0] PhAttack  = 3'd0;
	localparam logic [PhaseW-1:0] PhDecay   = 3'd1;
	localparam logic [PhaseW-1:0] PhSustain = 3'd2;
	localparam logic [PhaseW-1:0] PhRelease = 3'd3;
	localparam logic [PhaseW-1:0] PhStopped = 3'd4;

	// register indexes
	localparam logic [CfgAddrW-1:0] RegAttackStep    = 2'd0;
	localparam logic [CfgAddrW-1:0] RegDecayFactor   = 2'd1;
	localparam logic [CfgAddrW-1:0] RegSustainLevel  = 2'd2;
	localparam logic [CfgAddrW-1:0] RegReleaseFactor = 2'd3;

	// register values as seen by the datapath, sustain already saturated
	typedef struct packed {
		logic [LevelW-1:0]  attack_step;
		logic [FactorW-1:0] decay_factor;
		logic [LevelW-1:0]  sustain;
		logic [FactorW-1:0] release_factor;
	} cfg_t;

endpackage

>>> hw/rtl/adsr_cfg_regs.sv
// configuration register file for the envelope generator
// depends on adsr_pkg
module adsr_cfg_regs
	import adsr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgAddrW-1:0] cfg_addr,
	input  logic [LevelW-1:0]   cfg_wdata,
	output cfg_t                cfg
);

	logic [LevelW-1:0]  attack_step_q;
	logic [FactorW-1:0] decay_factor_q;
	logic [LevelW-1:0]  sustain_level_q;
	logic [FactorW-1:0] release_factor_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_step_q    <= 25'd218;
			decay_factor_q   <= 16'd65470;
			sustain_level_q  <= 25'd8388608;
			release_factor_q <= 16'd65470;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				RegAttackStep:    attack_step_q    <= cfg_wdata;
				RegDecayFactor:   decay_factor_q   <= cfg_wdata[FactorW-1:0];
				RegSustainLevel:  sustain_level_q  <= cfg_wdata;
				RegReleaseFactor: release_factor_q <= cfg_wdata[FactorW-1:0];
				default: ;
			endcase
		end
	end

	// sustain above full scale is clamped
	always_comb begin
		cfg.attack_step    = attack_step_q;
		cfg.decay_factor   = decay_factor_q;
		cfg.sustain        = (sustain_level_q > FullScale) ? FullScale : sustain_level_q;
		cfg.release_factor = release_factor_q;
	end

endmodule

>>> hw/rtl/adsr_mul.sv
// shared 25x16 unsigned multiplier with registered product
// depends on adsr_pkg
module adsr_mul
	import adsr_pkg::*;
(
	input  logic               clk,
	input  logic [LevelW-1:0]  a,
	input  logic [FactorW-1:0] b,
	output logic [ProdW-1:0]   prod_q
);

	// one product per cycle, available the cycle after
	always_ff @(posedge clk) begin
		prod_q <= ProdW'(a) * ProdW'(b);
	end

endmodule

>>> hw/rtl/adsr_envelope_generator_core.sv
// envelope generator top level: sequencer, envelope state and stream ports
// depends on adsr_pkg, adsr_cfg_regs, adsr_mul
//
// Usage:
// - s_axis carries one tick per item, tdata[0] is the gate level.
// - m_axis returns one result per tick: tdata[11:0] dac value,
//   tdata[14:12] phase after the tick (attack, decay, sustain, release, stopped).
// - cfg_we/cfg_addr/cfg_wdata write the four registers; write them only
//   while no tick is in flight.
// - From acceptance to result a tick goes through an attack add step,
//   an optional decay multiply, the sustain/gate step, an optional release
//   multiply and the dac multiply. All multiplies go through the one shared
//   25x16 multiplier, each as a multiply state and then a finish state.
// - s_axis_tready is high only while the sequencer is idle; one tick is
//   worked on at a time, so a new tick is taken only once the last has left it.
// - The result sits in an output register; the next tick is taken while it
//   waits. A stalled receiver holds the sequencer in its final step.
// - Reset puts the level at zero, the phase at stopped, the last gate low and
//   the registers at their defaults.
module adsr_envelope_generator_core
	import adsr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// tick input
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [7:0]          s_axis_tdata,   // [0] gate_level, [7:1] zero
	// result output
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [15:0]         m_axis_tdata,   // [11:0] dac_value, [14:12] phase, [15] zero
	// configuration
	input  logic                cfg_we,
	input  logic [CfgAddrW-1:0] cfg_addr,
	input  logic [LevelW-1:0]   cfg_wdata
);

	localparam logic [3:0] SIdle    = 4'd0;
	localparam logic [3:0] SAttack  = 4'd1;
	localparam logic [3:0] SDecMul  = 4'd2;
	localparam logic [3:0] SDecFin  = 4'd3;
	localparam logic [3:0] SSustain = 4'd4;
	localparam logic [3:0] SRelMul  = 4'd5;
	localparam logic [3:0] SRelFin  = 4'd6;
	localparam logic [3:0] SDacMul  = 4'd7;
	localparam logic [3:0] SDacFin  = 4'd8;

	cfg_t cfg;

	logic [3:0]         state_q;
	logic [LevelW-1:0]  level_q;
	logic [PhaseW-1:0]  phase_q;
	logic               last_gate_q;
	logic               gate_q;
	logic               above_q;
	logic               out_valid_q;
	logic [DacW-1:0]    out_dac_q;
	logic [PhaseW-1:0]  out_phase_q;

	logic [LevelW-1:0]  mul_a;
	logic [FactorW-1:0] mul_b;
	logic [ProdW-1:0]   prod_q;

	logic               in_fire;
	logic               gate_in;
	logic [LevelW:0]    att_sum;
	logic               dec_above;
	logic [LevelW-1:0]  dec_diff;
	logic [LevelW-1:0]  prod_hi;
	logic [LevelW:0]    sus_limit;
	logic [PhaseW-1:0]  sus_phase;
	logic [PhaseW-1:0]  gate_phase;

	adsr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	adsr_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	assign s_axis_tready = (state_q == SIdle);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign gate_in       = s_axis_tdata[0];

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_phase_q, out_dac_q};

	// attack add, decay distance and sustain/gate decisions
	always_comb begin
		att_sum   = {1'b0, level_q} + {1'b0, cfg.attack_step};
		dec_above = (level_q >= cfg.sustain);
		dec_diff  = dec_above ? (level_q - cfg.sustain) : (cfg.sustain - level_q);
		prod_hi   = prod_q[ProdW-1:FactorW];
		sus_limit = {1'b0, cfg.sustain} + {1'b0, Margin};
		sus_phase = ((phase_q == PhDecay) && ({1'b0, level_q} <= sus_limit)) ?
			PhSustain : phase_q;
		gate_phase = ((sus_phase <= PhSustain) && !gate_q) ? PhRelease : sus_phase;
	end

	// multiplier operand select
	always_comb begin
		mul_a = level_q;
		mul_b = DacMax;
		unique case (state_q)
			SDecMul: begin
				mul_a = dec_diff;
				mul_b = cfg.decay_factor;
			end
			SRelMul: begin
				mul_b = cfg.release_factor;
			end
			default: ;
		endcase
	end

	// tick sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SIdle;
			level_q     <= '0;
			phase_q     <= PhStopped;
			last_gate_q <= 1'b0;
			gate_q      <= 1'b0;
			above_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result register: loaded at the final step, cleared when taken
			if (state_q == SDacFin && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				SIdle: begin
					if (in_fire) begin
						gate_q      <= gate_in;
						last_gate_q <= gate_in;
						if (gate_in && !last_gate_q) begin
							phase_q <= PhAttack;
						end
						state_q <= SAttack;
					end
				end
				SAttack: begin
					if (phase_q == PhAttack) begin
						if (att_sum >= {1'b0, FullScale}) begin
							level_q <= FullScale;
							phase_q <= PhDecay;
						end else begin
							level_q <= att_sum[LevelW-1:0];
						end
					end
					state_q <= (phase_q == PhAttack && att_sum >= {1'b0, FullScale}) ||
						phase_q == PhDecay ? SDecMul : SSustain;
				end
				SDecMul: begin
					above_q <= dec_above;
					state_q <= SDecFin;
				end
				SDecFin: begin
					level_q <= above_q ? (cfg.sustain + prod_hi) : (cfg.sustain - prod_hi);
					state_q <= SSustain;
				end
				SSustain: begin
					if (sus_phase == PhSustain) begin
						level_q <= cfg.sustain;
					end
					phase_q <= gate_phase;
					state_q <= (gate_phase == PhRelease) ? SRelMul : SDacMul;
				end
				SRelMul: begin
					state_q <= SRelFin;
				end
				SRelFin: begin
					if (prod_hi <= Margin) begin
						level_q <= '0;
						phase_q <= PhStopped;
					end else begin
						level_q <= prod_hi;
					end
					state_q <= SDacMul;
				end
				SDacMul: begin
					state_q <= SDacFin;
				end
				SDacFin: begin
					if (!out_valid_q || m_axis_tready) begin
						state_q <= SIdle;
					end
				end
				default: begin
					state_q <= SIdle;
				end
			endcase
		end
	end

	// result payload, dac = (level * 4095) >> 24
	always_ff @(posedge clk) begin
		if (state_q == SDacFin && (!out_valid_q || m_axis_tready)) begin
			out_dac_q   <= prod_q[24+DacW-1:24];
			out_phase_q <= (phase_q > PhStopped) ? PhStopped : phase_q;
		end
	end

endmodule

>>> hw/rtl/adsr_checker.sv
// port-level assertions for the envelope generator, bound to the top level
// depends on adsr_pkg and adsr_envelope_generator_core
module adsr_checker
	import adsr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// one tick at a time: no new item the cycle after one is taken
	a_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("item taken while a tick is in work");

	// reported phase is a real phase code
	a_phase_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[14:12] <= PhStopped && !m_axis_tdata[15])
		else $error("bad phase code in result");

	// a stopped envelope sits at zero
	a_stopped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[14:12] == PhStopped |-> m_axis_tdata[11:0] == 12'd0)
		else $error("stopped envelope not at zero");

endmodule

bind adsr_envelope_generator_core adsr_checker u_adsr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

>>> tb/tb_adsr_envelope_generator_core.sv
// self-checking testbench for the envelope generator core: tick stream in, dac/phase out
// depends on adsr_pkg and the adsr_envelope_generator_core rtl; a local envelope
// predictor works out each result, with random stalls on both stream sides
module tb_adsr_envelope_generator_core;
	import adsr_pkg::*;

	localparam int StallLimit    = 3000;
	localparam int SettleCycles  = 12;
	localparam int HoldOffCycles = 300;

	typedef struct packed {
		logic [DacW-1:0]   dac_value;
		logic [PhaseW-1:0] phase;
	} env_result_t;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata;   // [0] gate_level, [7:1] zero
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [15:0]         m_axis_tdata;   // [11:0] dac_value, [14:12] phase, [15] zero
	logic                cfg_we;
	logic [CfgAddrW-1:0] cfg_addr;
	logic [LevelW-1:0]   cfg_wdata;

	// predicted envelope state and register copies
	logic [LevelW-1:0]  env_level;
	logic [PhaseW-1:0]  env_phase;
	logic               env_last_gate;
	logic [LevelW-1:0]  reg_attack_step;
	logic [FactorW-1:0] reg_decay_factor;
	logic [LevelW-1:0]  reg_sustain_level;
	logic [FactorW-1:0] reg_release_factor;

	env_result_t pending_env_q[$];

	int  ticks_sent;
	int  results_seen;
	int  reg_writes;
	int  err_count;
	int  idle_cycles;
	int  hold_off_len;
	bit  no_idle;

	adsr_envelope_generator_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always #5 clk = ~clk;

	// gap length: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	// one envelope tick: attack, decay, sustain, gate-low check, release
	function automatic env_result_t advance_envelope(input logic gate);
		logic [63:0] lvl;
		logic [63:0] sus;
		logic [63:0] diff;
		env_result_t res;
		sus = (reg_sustain_level > FullScale) ? 64'(FullScale) : 64'(reg_sustain_level);
		lvl = 64'(env_level);
		if (gate && !env_last_gate)
			env_phase = PhAttack;
		if (env_phase == PhAttack) begin
			lvl = lvl + reg_attack_step;
			if (lvl >= FullScale) begin
				lvl = 64'(FullScale);
				env_phase = PhDecay;
			end
		end
		// decay truncates toward the sustain level from either side
		if (env_phase == PhDecay) begin
			if (lvl >= sus) begin
				diff = lvl - sus;
				lvl = sus + ((diff * reg_decay_factor) >> 16);
			end else begin
				diff = sus - lvl;
				lvl = sus - ((diff * reg_decay_factor) >> 16);
			end
			if (lvl <= sus + Margin)
				env_phase = PhSustain;
		end
		if (env_phase == PhSustain)
			lvl = sus;
		if (env_phase <= PhSustain && !gate)
			env_phase = PhRelease;
		if (env_phase == PhRelease) begin
			lvl = (lvl * reg_release_factor) >> 16;
			if (lvl <= Margin) begin
				env_phase = PhStopped;
				lvl = '0;
			end
		end
		if (env_phase > PhStopped)
			env_phase = PhStopped;
		env_last_gate = gate;
		env_level = lvl[LevelW-1:0];
		res.dac_value = DacW'((lvl * DacMax) >> 24);
		res.phase = env_phase;
		return res;
	endfunction

	// register write, only while nothing is in flight
	task automatic write_env_reg(input logic [CfgAddrW-1:0] idx, input logic [LevelW-1:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			RegAttackStep:    reg_attack_step = value;
			RegDecayFactor:   reg_decay_factor = value[FactorW-1:0];
			RegSustainLevel:  reg_sustain_level = value;
			RegReleaseFactor: reg_release_factor = value[FactorW-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// offer one tick item and record its expected result once accepted
	task automatic send_tick(input logic gate);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'b0, gate};
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_env_q.push_back(advance_envelope(gate));
		ticks_sent++;
	endtask

	task automatic send_gate_bits(input logic [7:0] bits, input int n);
		for (int i = 0; i < n; i++)
			send_tick(bits[i]);
	endtask

	task automatic send_gate_run(input logic gate, input int n);
		for (int i = 0; i < n; i++)
			send_tick(gate);
	endtask

	// mostly a held note then a released stretch, sometimes a noisy gate
	task automatic send_gate_pattern();
		int n;
		if ($urandom_range(0, 99) < 85) begin
			send_gate_run(1'b1, $urandom_range(1, 40));
			send_gate_run(1'b0, $urandom_range(1, 30));
		end else begin
			n = $urandom_range(1, 10);
			for (int i = 0; i < n; i++)
				send_tick(1'($urandom_range(0, 1)));
		end
	endtask

	// stop offering, wait for every pending result, then let the pipe settle
	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_env_q.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// registers at their reset values: stopped stays stopped, short attack, release
	task automatic test_reset_defaults();
		send_gate_bits(8'b0001_1100, 7);
		wait_results_drained();
	endtask

	// register extremes and the named special cases
	task automatic test_register_extremes();
		// full step, zero factors: attack to full, straight to sustain at zero, stop
		write_env_reg(RegAttackStep, FullScale);
		write_env_reg(RegDecayFactor, '0);
		write_env_reg(RegSustainLevel, '0);
		write_env_reg(RegReleaseFactor, '0);
		send_gate_bits(8'b0000_0011, 4);
		wait_results_drained();
		// sustain above full scale saturates, slowest decay and release
		write_env_reg(RegSustainLevel, 25'h1FF_FFFF);
		write_env_reg(RegDecayFactor, 25'd65535);
		write_env_reg(RegReleaseFactor, 25'd65535);
		send_gate_bits(8'b0000_0011, 4);
		wait_results_drained();
		// zero attack step holds the level while the gate is high
		write_env_reg(RegAttackStep, '0);
		write_env_reg(RegSustainLevel, FullScale);
		send_gate_bits(8'b0000_0011, 3);
		wait_results_drained();
		// oversized step clamps, retrigger from release
		write_env_reg(RegAttackStep, 25'h1FF_FFFF);
		write_env_reg(RegDecayFactor, 25'd1);
		write_env_reg(RegSustainLevel, FullScale >> 2);
		write_env_reg(RegReleaseFactor, 25'd32768);
		send_gate_bits(8'b0000_1101, 6);
		wait_results_drained();
	endtask

	// several random register settings, each with gate patterns
	task automatic test_random_envelopes();
		int r;
		int target;
		logic [LevelW-1:0] value;
		for (int round = 0; round < 5; round++) begin
			for (int idx = 0; idx < 4; idx++) begin
				r = $urandom_range(0, 99);
				case (idx[CfgAddrW-1:0])
					RegAttackStep: begin
						// most steps reach full scale within a couple dozen ticks
						if (r < 70)
							value = LevelW'(FullScale / $urandom_range(1, 24));
						else if (r < 85)
							value = LevelW'($urandom_range(1, FullScale));
						else if (r < 95)
							value = LevelW'($urandom());
						else
							value = '0;
					end
					RegSustainLevel: begin
						if (r < 70)
							value = LevelW'($urandom_range(0, FullScale));
						else if (r < 85)
							value = LevelW'($urandom());
						else
							value = (r % 2) ? FullScale : '0;
					end
					default: begin
						// factors kept mostly fast so phases complete
						if (r < 70)
							value = LevelW'($urandom_range(0, 52000));
						else if (r < 90)
							value = LevelW'($urandom_range(52001, 65535));
						else
							value = (r % 2) ? 25'd65535 : 25'd0;
					end
				endcase
				write_env_reg(idx[CfgAddrW-1:0], value);
			end
			target = ticks_sent + 60;
			while (ticks_sent < target)
				send_gate_pattern();
			wait_results_drained();
		end
	endtask

	// receiver holds off while the sender keeps offering, so the input stalls
	task automatic test_output_stall();
		no_idle = 1'b1;
		hold_off_len = HoldOffCycles;
		send_gate_run(1'b1, 15);
		send_gate_run(1'b0, 15);
		no_idle = 1'b0;
		wait_results_drained();
	endtask

	// back-to-back items with the sender always offering and the receiver always ready
	task automatic test_back_to_back();
		int target;
		no_idle = 1'b1;
		target = ticks_sent + 60;
		while (ticks_sent < target)
			send_gate_pattern();
		no_idle = 1'b0;
		wait_results_drained();
	endtask

	task automatic note_mismatch(input string field, input int want, input int got);
		if (err_count < 10)
			$display("mismatch on %s at result %0d: expected %0d, got %0d",
				field, results_seen, want, got);
		err_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		env_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_env_q.size() == 0) begin
				note_mismatch("unexpected item", 0, int'(m_axis_tdata));
			end else begin
				want = pending_env_q.pop_front();
				if (m_axis_tdata[DacW-1:0] !== want.dac_value)
					note_mismatch("dac_value", int'(want.dac_value),
						int'(m_axis_tdata[DacW-1:0]));
				if (m_axis_tdata[DacW +: PhaseW] !== want.phase)
					note_mismatch("phase", int'(want.phase),
						int'(m_axis_tdata[DacW +: PhaseW]));
			end
			results_seen++;
		end
	end

	// watchdog on cycles with no item accepted on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("timeout: no item accepted for %0d cycles", idle_cycles);
			$display("FAIL");
			$finish;
		end
	end

	// receiver ready pattern, with a long hold-off on request
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_len > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_off_len) @(posedge clk);
				hold_off_len = 0;
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				gap = pick_gap();
				if (gap > 0) begin
					m_axis_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	// reset, then the tests in turn
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_addr = RegAttackStep;
		cfg_wdata = '0;
		idle_cycles = 0;
		hold_off_len = 0;
		no_idle = 1'b0;
		ticks_sent = 0;
		results_seen = 0;
		reg_writes = 0;
		err_count = 0;
		env_level = '0;
		env_phase = PhStopped;
		env_last_gate = 1'b0;
		reg_attack_step = 25'd218;
		reg_decay_factor = 16'd65470;
		reg_sustain_level = 25'd8388608;
		reg_release_factor = 16'd65470;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_random_envelopes();
		test_output_stall();
		test_back_to_back();

		if (pending_env_q.size() != 0)
			note_mismatch("results left over", 0, pending_env_q.size());
		$display("run: %0d ticks, %0d results checked, %0d register writes",
			ticks_sent, results_seen, reg_writes);
		$display("run: defaults, register extremes, retrigger, random settings, stalls, bursts");
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
